@@ rtl/core/structured_light_pattern_gen_core_macros.svh @@
// Assertion macros for the structured light pattern generator core.
// Included by the RTL files that carry concurrent checks; depends on nothing else.
`ifndef STRUCTURED_LIGHT_PATTERN_GEN_CORE_MACROS_SVH
`define STRUCTURED_LIGHT_PATTERN_GEN_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SLPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
        else $error("slpg: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define SLPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) \
        else $error("slpg: next-cycle check failed");
`else
`define SLPG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLPG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/slpg_pkg.sv @@
// Shared types, constants and cosine table functions for the pattern generator.
// Used by slpg_div_cell, slpg_level_out and structured_light_pattern_gen_core.
`default_nettype none
package slpg_pkg;

    // Field and port widths.
    localparam int unsigned COLUMN_W   = 10;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned PERIOD_W   = 13;
    localparam int unsigned SHIFT_W    = 17;
    localparam int unsigned GRAY_SEL_W = 4;
    localparam int unsigned MODE_W     = 2;

    // Divisor is 16 * period, so it needs four more bits than the period.
    localparam int unsigned DIV_W = PERIOD_W + 4;

    // Columns at or past the line end are black.
    localparam int unsigned LINE_WIDTH = 640;
    localparam int unsigned LINE_CMP_W = 13;

    // Default size of the cosine table, in address bits.
    localparam int unsigned PHASE_TABLE_BITS_DEF = 10;

    // Pattern modes.
    localparam logic [MODE_W-1:0] MODE_FLAT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FRINGE = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_BIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_SHIFT  = 3'd5;

    // Register reset values.
    localparam logic [LEVEL_W-1:0]  MAX_BRIGHT_RST = 8'd150;
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 13'd64;

    // Q1.15 unit and the Q30 constants of the table series.
    localparam logic [15:0] Q15_ONE    = 16'd32767;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

    // Sideband that rides along with every request through the pipeline.
    typedef struct packed {
        logic               fringe;  // level comes from the cosine path
        logic               neg;     // quotient must be negated (negative numerator)
        logic [LEVEL_W-1:0] level;   // finished level for flat, stripe and black
        logic [LEVEL_W-1:0] bright;  // fringe amplitude
    } t_side;

    // One Taylor step: divide by (2i-1)(2i) for term i of the cosine series.
    function automatic logic [63:0] taylor_div(input logic [63:0] num, input int unsigned i);
        case (i)
            1: return num / 64'd2;
            2: return num / 64'd12;
            3: return num / 64'd30;
            4: return num / 64'd56;
            5: return num / 64'd90;
            6: return num / 64'd132;
            7: return num / 64'd182;
            8: return num / 64'd240;
            default: return num;
        endcase
    endfunction

    // cos(2*pi*r/N) on the first quarter, as Q15 in 0..32767.
    function automatic logic [15:0] quarter_cos(input int unsigned r, input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        int unsigned        i;
        x    = (64'(r) * TWO_PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        for (i = 1; i <= 8; i++) begin
            term = taylor_div(term * x2, i);
            if ((i & 32'd1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[15:0];
    endfunction

    // Table entry k as 32767 + cos, so it is unsigned in 0..65534.
    function automatic logic [15:0] cos_rom_u(input int unsigned k, input int unsigned bits);
        int unsigned quarter;
        int unsigned kk;
        int unsigned quad;
        int unsigned r;
        quarter = 32'd1 << (bits - 2);
        kk      = k & ((32'd1 << bits) - 1);
        quad    = kk >> (bits - 2);
        r       = kk & (quarter - 1);
        case (quad)
            0: return Q15_ONE + quarter_cos(r, bits);
            1: return Q15_ONE - quarter_cos(quarter - r, bits);
            2: return Q15_ONE - quarter_cos(r, bits);
            default: return Q15_ONE + quarter_cos(quarter - r, bits);
        endcase
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/slpg_div_cell.sv @@
// One restoring-division step of the phase divider chain.
// Depends on slpg_pkg for the divisor width and the sideband type.
`default_nettype none
module slpg_div_cell #(
    parameter int unsigned BITS_W = 24,
    parameter int unsigned QUOT_W = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire slpg_pkg::t_side             i_side,
    input  wire logic [slpg_pkg::DIV_W-1:0]  i_rem,
    input  wire logic [BITS_W-1:0]           i_bits,
    input  wire logic [QUOT_W-1:0]           i_quot,
    input  wire logic [slpg_pkg::DIV_W-1:0]  i_div,
    output logic                             o_valid,
    output slpg_pkg::t_side                  o_side,
    output logic [slpg_pkg::DIV_W-1:0]       o_rem,
    output logic [BITS_W-1:0]                o_bits,
    output logic [QUOT_W-1:0]                o_quot,
    output logic [slpg_pkg::DIV_W-1:0]       o_div
);

    logic [slpg_pkg::DIV_W:0]   n_trial;
    logic [slpg_pkg::DIV_W:0]   n_diff;
    logic                       n_ge;
    logic [slpg_pkg::DIV_W-1:0] n_rem;

    logic                       r_valid;
    slpg_pkg::t_side            r_side;
    logic [slpg_pkg::DIV_W-1:0] r_rem;
    logic [BITS_W-1:0]          r_bits;
    logic [QUOT_W-1:0]          r_quot;
    logic [slpg_pkg::DIV_W-1:0] r_div;

    // Bring down the next numerator bit and subtract the divisor if it fits.
    always_comb begin
        n_trial = {i_rem, i_bits[BITS_W-1]};
        n_diff  = n_trial - {1'b0, i_div};
        n_ge    = (n_trial >= {1'b0, i_div});
        n_rem   = n_ge ? n_diff[slpg_pkg::DIV_W-1:0] : n_trial[slpg_pkg::DIV_W-1:0];
    end

    // Request valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload moves on every cycle; only the low quotient bits are kept.
    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_rem  <= n_rem;
        r_bits <= {i_bits[BITS_W-2:0], 1'b0};
        r_quot <= {i_quot[QUOT_W-2:0], n_ge};
        r_div  <= i_div;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_bits  = r_bits;
    assign o_quot  = r_quot;
    assign o_div   = r_div;

endmodule
`default_nettype wire

@@ rtl/core/slpg_level_out.sv @@
// Cosine table lookup and amplitude scaling that turn a phase index into a level.
// Depends on slpg_pkg for the table function, the sideband type and widths.
`default_nettype none
module slpg_level_out #(
    parameter int unsigned PHASE_TABLE_BITS = slpg_pkg::PHASE_TABLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire slpg_pkg::t_side               i_side,
    input  wire logic [PHASE_TABLE_BITS-1:0]   i_quot,
    output logic                               o_valid,
    output logic [slpg_pkg::LEVEL_W-1:0]       o_level
);

    localparam int unsigned ROM_SIZE = 1 << PHASE_TABLE_BITS;

    // Constant cosine table, offset by one unit so every entry is unsigned.
    logic [15:0] w_rom [ROM_SIZE];

    for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
        localparam logic [15:0] ENTRY = slpg_pkg::cos_rom_u(k, PHASE_TABLE_BITS);
        assign w_rom[k] = ENTRY;
    end

    logic [PHASE_TABLE_BITS-1:0] n_idx;
    logic [22:0]                 n_half;
    logic [23:0]                 n_sum;

    logic                        r_p1_valid;
    logic                        r_p2_valid;
    logic                        r_p3_valid;
    logic                        r_out_valid;
    slpg_pkg::t_side             r_p1_side;
    slpg_pkg::t_side             r_p2_side;
    slpg_pkg::t_side             r_p3_side;
    logic [PHASE_TABLE_BITS-1:0] r_p1_idx;
    logic [15:0]                 r_p2_u;
    logic [23:0]                 r_p3_prod;
    logic [slpg_pkg::LEVEL_W-1:0] r_level;

    // A negative numerator gives the negated quotient; wrap is free at table size.
    assign n_idx = i_side.neg
                 ? (~i_quot + {{(PHASE_TABLE_BITS-1){1'b0}}, 1'b1})
                 : i_quot;

    // Divide by 65534: halve, then divide by 2^15-1 as (w + (w >> 15) + 1) >> 15.
    always_comb begin
        n_half = r_p3_prod[23:1];
        n_sum  = {1'b0, n_half} + {16'd0, n_half[22:15]} + 24'd1;
    end

    // Request valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_valid  <= i_valid;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_out_valid <= r_p3_valid;
        end
    end

    // Index, table read, amplitude product and final level.
    always_ff @(posedge i_clk) begin
        r_p1_side <= i_side;
        r_p1_idx  <= n_idx;
        r_p2_side <= r_p1_side;
        r_p2_u    <= w_rom[r_p1_idx];
        r_p3_side <= r_p2_side;
        r_p3_prod <= {8'd0, r_p2_u} * {16'd0, r_p2_side.bright};
        r_level   <= r_p3_side.fringe ? n_sum[22:15] : r_p3_side.level;
    end

    assign o_valid = r_out_valid;
    assign o_level = r_level;

endmodule
`default_nettype wire

@@ rtl/core/structured_light_pattern_gen_core.sv @@
// Top level of the structured light pattern generator: registers, front end, divider chain.
// Depends on slpg_pkg, slpg_div_cell, slpg_level_out and the assertion macro header.
`default_nettype none
`include "structured_light_pattern_gen_core_macros.svh"
// The core takes one column request per clock while busy is low and returns its
// gray level in every mode, so results leave in request order at the same rate
// they enter. A request passes three front-end stages, then the phase divider, a
// chain of PHASE_TABLE_BITS + 14 restoring-division cells, one quotient bit per
// cell, and then four stages of table lookup and scaling. The receiver cannot
// stall: o_valid marks each level for exactly one cycle. busy is high only
// while reset is applied and for the first cycle after it; start is ignored
// while busy is high. Configuration writes take effect at once and must only
// be made while no request is in flight.
module structured_light_pattern_gen_core #(
    parameter int unsigned PHASE_TABLE_BITS = slpg_pkg::PHASE_TABLE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [slpg_pkg::COLUMN_W-1:0]    i_column,
    output logic                                  o_valid,
    output logic [slpg_pkg::LEVEL_W-1:0]          o_level,
    input  wire logic                             i_cfg_we,
    input  wire logic [slpg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [slpg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    // Numerator (16*column - shift) * N + 8*period, signed, and its magnitude form.
    localparam int unsigned X_W = PHASE_TABLE_BITS + 19;
    localparam int unsigned A_W = X_W - 1;
    // Divisor is at least 16, so the quotient has four bits fewer than the numerator.
    localparam int unsigned QW  = A_W - 4;
    localparam int unsigned LAT = QW + 7;

    // Configuration registers.
    logic [slpg_pkg::MODE_W-1:0]     r_pattern_mode;
    logic [slpg_pkg::GRAY_SEL_W-1:0] r_gray_bit;
    logic                            r_invert;
    logic [slpg_pkg::LEVEL_W-1:0]    r_max_bright;
    logic [slpg_pkg::PERIOD_W-1:0]   r_period;
    logic [slpg_pkg::SHIFT_W-1:0]    r_phase_shift;
    logic                            r_busy;

    logic w_accept;

    // Front-end comb values.
    logic                            n_in_line;
    logic [slpg_pkg::COLUMN_W-1:0]   n_gray;
    logic [15:0]                     n_gray_ext;
    logic                            n_gray_sel;
    slpg_pkg::t_side                 n_side;
    logic signed [17:0]              n_d;
    logic [slpg_pkg::PERIOD_W-1:0]   n_per;
    logic [X_W-1:0]                  n_x;
    logic [A_W-1:0]                  n_a;
    logic                            n_neg;
    slpg_pkg::t_side                 n_s2_side;

    // Front-end stage registers.
    logic                            r_s0_valid;
    slpg_pkg::t_side                 r_s0_side;
    logic signed [17:0]              r_s0_d;
    logic [slpg_pkg::PERIOD_W-1:0]   r_s0_per;
    logic                            r_s1_valid;
    slpg_pkg::t_side                 r_s1_side;
    logic [X_W-1:0]                  r_s1_x;
    logic [slpg_pkg::DIV_W-1:0]      r_s1_div;
    logic                            r_s2_valid;
    slpg_pkg::t_side                 r_s2_side;
    logic [slpg_pkg::DIV_W-1:0]      r_s2_rem;
    logic [QW-1:0]                   r_s2_bits;
    logic [slpg_pkg::DIV_W-1:0]      r_s2_div;

    // Divider chain links.
    logic                            w_cv    [QW+1];
    slpg_pkg::t_side                 w_cside [QW+1];
    logic [slpg_pkg::DIV_W-1:0]      w_crem  [QW+1];
    logic [QW-1:0]                   w_cbits [QW+1];
    logic [PHASE_TABLE_BITS-1:0]     w_cquot [QW+1];
    logic [slpg_pkg::DIV_W-1:0]      w_cdiv  [QW+1];

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_mode <= slpg_pkg::MODE_FLAT;
            r_gray_bit     <= '0;
            r_invert       <= 1'b0;
            r_max_bright   <= slpg_pkg::MAX_BRIGHT_RST;
            r_period       <= slpg_pkg::PERIOD_RST;
            r_phase_shift  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slpg_pkg::REG_PATTERN_MODE: r_pattern_mode <= i_cfg_wdata[1:0];
                slpg_pkg::REG_GRAY_BIT:     r_gray_bit     <= i_cfg_wdata[3:0];
                slpg_pkg::REG_INVERT:       r_invert       <= i_cfg_wdata[0];
                slpg_pkg::REG_MAX_BRIGHT:   r_max_bright   <= i_cfg_wdata[7:0];
                slpg_pkg::REG_PERIOD:       r_period       <= i_cfg_wdata[12:0];
                slpg_pkg::REG_PHASE_SHIFT:  r_phase_shift  <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // Busy covers reset and the cycle right after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start & ~r_busy;

    // Level for flat, stripe and off-line columns is settled at the request.
    always_comb begin
        n_in_line  = ({3'b000, i_column} < slpg_pkg::LINE_CMP_W'(slpg_pkg::LINE_WIDTH));
        n_gray     = i_column ^ (i_column >> 1);
        n_gray_ext = {6'd0, n_gray};
        n_gray_sel = n_gray_ext[r_gray_bit];
        n_side        = '0;
        n_side.bright = r_max_bright;
        case (r_pattern_mode)
            slpg_pkg::MODE_FLAT:   n_side.level  = r_max_bright;
            slpg_pkg::MODE_GRAY:   n_side.level  = (n_gray_sel ^ r_invert) ? '0 : r_max_bright;
            slpg_pkg::MODE_FRINGE: n_side.fringe = 1'b1;
            default:               n_side.level  = '0;
        endcase
        if (!n_in_line) begin
            n_side.level  = '0;
            n_side.fringe = 1'b0;
        end
        n_d   = $signed({4'b0000, i_column, 4'b0000}) - $signed({r_phase_shift[16], r_phase_shift});
        n_per = (r_period == '0) ? {{(slpg_pkg::PERIOD_W-1){1'b0}}, 1'b1} : r_period;
    end

    // Scale to table units and add half a divisor for rounding.
    assign n_x = {r_s0_d[17], r_s0_d, {PHASE_TABLE_BITS{1'b0}}}
               + {{(X_W-16){1'b0}}, r_s0_per, 3'b000};

    // Floor of a negative numerator: divide (-x + m - 1) and negate the quotient later.
    always_comb begin
        n_neg     = r_s1_x[X_W-1];
        n_a       = n_neg ? (~r_s1_x[A_W-1:0] + {{(A_W-slpg_pkg::DIV_W){1'b0}}, r_s1_div})
                          : r_s1_x[A_W-1:0];
        n_s2_side     = r_s1_side;
        n_s2_side.neg = n_neg;
    end

    // Front-end valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s0_valid <= w_accept;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Front-end payload.
    always_ff @(posedge i_clk) begin
        r_s0_side <= n_side;
        r_s0_d    <= n_d;
        r_s0_per  <= n_per;
        r_s1_side <= r_s0_side;
        r_s1_x    <= n_x;
        r_s1_div  <= {r_s0_per, 4'b0000};
        r_s2_side <= n_s2_side;
        r_s2_rem  <= {{(slpg_pkg::DIV_W-4){1'b0}}, n_a[A_W-1:QW]};
        r_s2_bits <= n_a[QW-1:0];
        r_s2_div  <= r_s1_div;
    end

    // Head of the divider chain.
    assign w_cv[0]    = r_s2_valid;
    assign w_cside[0] = r_s2_side;
    assign w_crem[0]  = r_s2_rem;
    assign w_cbits[0] = r_s2_bits;
    assign w_cquot[0] = '0;
    assign w_cdiv[0]  = r_s2_div;

    // One quotient bit per cell.
    for (genvar k = 0; k < QW; k++) begin : g_chain
        slpg_div_cell #(
            .BITS_W (QW),
            .QUOT_W (PHASE_TABLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[k]),
            .i_side  (w_cside[k]),
            .i_rem   (w_crem[k]),
            .i_bits  (w_cbits[k]),
            .i_quot  (w_cquot[k]),
            .i_div   (w_cdiv[k]),
            .o_valid (w_cv[k+1]),
            .o_side  (w_cside[k+1]),
            .o_rem   (w_crem[k+1]),
            .o_bits  (w_cbits[k+1]),
            .o_quot  (w_cquot[k+1]),
            .o_div   (w_cdiv[k+1])
        );
    end

    // Table lookup, scaling and the output register.
    slpg_level_out #(
        .PHASE_TABLE_BITS (PHASE_TABLE_BITS)
    ) u_level_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cv[QW]),
        .i_side  (w_cside[QW]),
        .i_quot  (w_cquot[QW]),
        .o_valid (o_valid),
        .o_level (o_level)
    );

    // Busy drops in the cycle after reset is released.
    `SLPG_ASSERT_NXT(a_busy_release, i_clk, i_rst_n, 1'b1, !busy)
    // Every accepted request yields a level once it has passed the whole pipeline.
    `SLPG_ASSERT_IMP(a_fixed_latency, i_clk, i_rst_n, w_accept, ##LAT o_valid)
    // No level appears without an accepted request behind it.
    `SLPG_ASSERT_IMP(a_no_extra_result, i_clk, i_rst_n, o_valid, $past(w_accept, LAT))
    // At the chain end all numerator bits are consumed and the remainder is reduced.
    `SLPG_ASSERT_IMP(a_div_done, i_clk, i_rst_n, w_cv[QW],
        (w_crem[QW] < w_cdiv[QW]) && (w_cbits[QW] == '0))

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for structured_light_pattern_gen_core.
// Uses slpg_pkg for widths, mode codes and register indexes; needs only the RTL.
// Holds its own level predictor and cosine table, sends column requests and checks each level.
`timescale 1ns / 1ps

module tb_top;

    import slpg_pkg::*;

    typedef longint unsigned u64_t;

    // Cosine table geometry at the default table size.
    localparam int unsigned TABLE_BITS = PHASE_TABLE_BITS_DEF;
    localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;
    localparam int unsigned QUARTER    = TABLE_SIZE / 4;

    // Codes the block must ignore or treat as black.
    localparam logic [MODE_W-1:0]    MODE_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 3'd7;

    localparam int unsigned ITEM_TARGET = 1850;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned TAIL_CYCLES = 40;

    typedef struct {
        logic [COLUMN_W-1:0] column;
        logic [LEVEL_W-1:0]  level;
    } level_req_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [COLUMN_W-1:0]   i_column;
    logic                  o_valid;
    logic [LEVEL_W-1:0]    o_level;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Shadow copy of the configuration registers.
    logic [MODE_W-1:0]         cur_mode;
    logic [GRAY_SEL_W-1:0]     cur_gray_sel;
    logic                      cur_invert;
    logic [LEVEL_W-1:0]        cur_bright;
    logic [PERIOD_W-1:0]       cur_period;
    logic signed [SHIFT_W-1:0] cur_shift;

    int          cos_table_q15 [0:TABLE_SIZE-1];
    level_req_t  pending_levels [$];
    level_req_t  head;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned items_sent;

    structured_light_pattern_gen_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_column    (i_column),
        .o_valid     (o_valid),
        .o_level     (o_level),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run-length guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Compare every level strobe with the oldest outstanding request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected level: expected none, actual %0d", $time, o_level);
                mismatch_count++;
            end else begin
                head = pending_levels.pop_front();
                if (o_level !== head.level) begin
                    $display("%0t: level of column %0d: expected %0d, actual %0d",
                             $time, head.column, head.level, o_level);
                    mismatch_count++;
                end
            end
        end
    end

    // cos(2*pi*r/N) on the first quadrant in Q15, from a Q30 Taylor series.
    function automatic int cos_first_quadrant(input int unsigned r);
        u64_t        ang;
        u64_t        ang_sq;
        u64_t        term;
        u64_t        scaled;
        longint      acc;
        int unsigned k;
        ang    = (u64_t'(r) * TWO_PI_Q30) >> TABLE_BITS;
        ang_sq = (ang * ang) >> 30;
        term   = ONE_Q30;
        acc    = longint'(ONE_Q30);
        for (k = 1; k <= 8; k++) begin
            term = (term * ang_sq) / u64_t'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(ONE_Q30)) begin
            acc = longint'(ONE_Q30);
        end
        scaled = (u64_t'(acc) * 32767 + (u64_t'(1) << 29)) >> 30;
        if (scaled > 32767) begin
            scaled = 32767;
        end
        return int'(scaled);
    endfunction

    // Expected gray level of one column under the current configuration.
    function automatic logic [LEVEL_W-1:0] predict_level(input logic [COLUMN_W-1:0] col);
        longint      per;
        longint      span;
        longint      offset;
        longint      idx;
        longint      lvl;
        int unsigned gray;
        if (col >= LINE_WIDTH) begin
            return '0;
        end
        case (cur_mode)
            MODE_FLAT: begin
                return cur_bright;
            end
            MODE_GRAY: begin
                gray = int'(col) ^ (int'(col) >> 1);
                if ((((gray >> cur_gray_sel) & 1) ^ cur_invert) != 0) begin
                    return '0;
                end
                return cur_bright;
            end
            MODE_FRINGE: begin
                // A zero period behaves as a period of one column.
                per    = (cur_period == 0) ? 1 : longint'(cur_period);
                span   = 16 * per;
                offset = (16 * longint'(col) - longint'(cur_shift)) % span;
                if (offset < 0) begin
                    offset += span;
                end
                idx = (offset * TABLE_SIZE + span / 2) / span;
                lvl = ((32767 + cos_table_q15[idx % TABLE_SIZE]) * longint'(cur_bright)) / 65534;
                return lvl[LEVEL_W-1:0];
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    // Random junk above the register's own bits, which the block must drop.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                         input int unsigned width);
        logic [CFG_DATA_W-1:0] mask;
        mask = (CFG_DATA_W'(1) << width) - 1;
        if ($urandom_range(0, 3) != 0) begin
            return value;
        end
        return (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
    endfunction

    // Register write, made only once every request in flight has returned.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        start = 1'b0;
        while (pending_levels.size() != 0) begin
            @(negedge i_clk);
        end
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        case (idx)
            REG_PATTERN_MODE: cur_mode     = data[MODE_W-1:0];
            REG_GRAY_BIT:     cur_gray_sel = data[GRAY_SEL_W-1:0];
            REG_INVERT:       cur_invert   = data[0];
            REG_MAX_BRIGHT:   cur_bright   = data[LEVEL_W-1:0];
            REG_PERIOD:       cur_period   = data[PERIOD_W-1:0];
            REG_PHASE_SHIFT:  cur_shift    = data[SHIFT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Send one column request; called at a falling edge, returns at one.
    task automatic send_column(input logic [COLUMN_W-1:0] col);
        level_req_t req;
        start    = 1'b1;
        i_column = col;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        @(negedge i_clk);
        req.column = col;
        req.level  = predict_level(col);
        pending_levels.push_back(req);
        items_sent++;
    endtask

    // Idle gap between requests: mostly none, some short, a few long.
    task automatic idle_gap();
        int unsigned pick;
        int unsigned cycles;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            cycles = 0;
        end else if (pick < 90) begin
            cycles = $urandom_range(1, 3);
        end else begin
            cycles = $urandom_range(8, 40);
        end
        if (cycles != 0) begin
            start = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Reset values and the line edges in flat mode.
    task automatic test_reset_state();
        send_column(10'd0);
        send_column(10'd639);
        send_column(10'd640);
        send_column(10'd1023);
    endtask

    // Flat field at both brightness extremes.
    task automatic test_flat_extremes();
        cfg_write(REG_MAX_BRIGHT, 17'd0);
        send_column(10'd5);
        cfg_write(REG_MAX_BRIGHT, 17'd255);
        send_column(10'd638);
    endtask

    // Stripe planes, both polarities, and bits beyond the column width.
    task automatic test_gray_planes();
        cfg_write(REG_PATTERN_MODE, 17'(MODE_GRAY));
        cfg_write(REG_MAX_BRIGHT, 17'd200);
        cfg_write(REG_GRAY_BIT, 17'd0);
        cfg_write(REG_INVERT, 17'd0);
        send_column(10'd1);
        send_column(10'd2);
        cfg_write(REG_GRAY_BIT, 17'd9);
        cfg_write(REG_INVERT, 17'd1);
        send_column(10'd512);
        send_column(10'd639);
        cfg_write(REG_GRAY_BIT, 17'd11);
        send_column(10'd300);
        cfg_write(REG_GRAY_BIT, 17'd15);
        cfg_write(REG_INVERT, 17'd0);
        send_column(10'd600);
    endtask

    // Fringe at the period and shift extremes, zero period, oversized period.
    task automatic test_fringe();
        cfg_write(REG_PATTERN_MODE, 17'(MODE_FRINGE));
        cfg_write(REG_MAX_BRIGHT, 17'd255);
        cfg_write(REG_PERIOD, 17'd64);
        cfg_write(REG_PHASE_SHIFT, 17'd0);
        send_column(10'd0);
        send_column(10'd16);
        send_column(10'd32);
        cfg_write(REG_PERIOD, 17'd1);
        cfg_write(REG_PHASE_SHIFT, 17'h10000);
        send_column(10'd7);
        cfg_write(REG_PERIOD, 17'd0);
        cfg_write(REG_PHASE_SHIFT, 17'h0FFFF);
        send_column(10'd100);
        cfg_write(REG_PERIOD, 17'd8191);
        cfg_write(REG_PHASE_SHIFT, 17'd12345);
        send_column(10'd639);
        cfg_write(REG_PERIOD, 17'd4096);
        send_column(10'd1000);
    endtask

    // Unused mode gives black; writes to spare indexes change nothing.
    task automatic test_unused_codes();
        cfg_write(REG_PATTERN_MODE, 17'(MODE_UNUSED));
        send_column(10'd10);
        cfg_write(REG_PATTERN_MODE, 17'(MODE_FLAT));
        cfg_write(CFG_IDX_SPARE0, 17'h1FFFF);
        cfg_write(CFG_IDX_SPARE1, 17'h00003);
        send_column(10'd20);
    endtask

    // Random configuration phases, each followed by a burst of columns.
    task automatic test_random_phases();
        int unsigned           pick;
        int unsigned           burst;
        int unsigned           n;
        bit                    quiet;
        logic [CFG_DATA_W-1:0] val;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                val = 17'(MODE_FLAT);
            end else if (pick < 8) begin
                val = 17'(MODE_GRAY);
            end else if (pick < 18) begin
                val = 17'(MODE_FRINGE);
            end else begin
                val = 17'(MODE_UNUSED);
            end
            cfg_write(REG_PATTERN_MODE, with_junk(val, MODE_W));
            if ($urandom_range(0, 1) == 0) begin
                cfg_write(REG_GRAY_BIT, with_junk(17'($urandom_range(0, 15)), GRAY_SEL_W));
            end
            if ($urandom_range(0, 1) == 0) begin
                cfg_write(REG_INVERT, with_junk(17'($urandom_range(0, 1)), 1));
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 7))
                    0: val = 17'd0;
                    1: val = 17'd255;
                    default: val = 17'($urandom_range(0, 255));
                endcase
                cfg_write(REG_MAX_BRIGHT, with_junk(val, LEVEL_W));
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0: val = 17'd0;
                    1: val = 17'd1;
                    2: val = 17'd4096;
                    3: val = 17'd8191;
                    4, 5: val = 17'($urandom_range(0, 8191));
                    default: val = 17'($urandom_range(1, 64));
                endcase
                cfg_write(REG_PERIOD, with_junk(val, PERIOD_W));
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 7))
                    0: val = 17'h10000;
                    1: val = 17'h0FFFF;
                    default: val = 17'($urandom);
                endcase
                cfg_write(REG_PHASE_SHIFT, val);
            end
            if ($urandom_range(0, 9) == 0) begin
                cfg_write(($urandom_range(0, 1) == 0) ? CFG_IDX_SPARE0 : CFG_IDX_SPARE1,
                          17'($urandom));
            end
            burst = $urandom_range(20, 120);
            quiet = ($urandom_range(0, 3) == 0);
            for (n = 0; n < burst && items_sent < ITEM_TARGET; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_column(10'($urandom_range(640, 1023)));
                end else begin
                    send_column(10'($urandom_range(0, 639)));
                end
                if (!quiet) begin
                    idle_gap();
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        int unsigned k;
        int unsigned quad;
        int unsigned r;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_column       = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_wdata    = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        cur_mode       = MODE_FLAT;
        cur_gray_sel   = '0;
        cur_invert     = 1'b0;
        cur_bright     = MAX_BRIGHT_RST;
        cur_period     = PERIOD_RST;
        cur_shift      = '0;

        // Full-period cosine table built by folding into the first quadrant.
        for (k = 0; k < TABLE_SIZE; k++) begin
            quad = k / QUARTER;
            r    = k % QUARTER;
            case (quad)
                0: cos_table_q15[k] = cos_first_quadrant(r);
                1: cos_table_q15[k] = -cos_first_quadrant(QUARTER - r);
                2: cos_table_q15[k] = -cos_first_quadrant(r);
                default: cos_table_q15[k] = cos_first_quadrant(QUARTER - r);
            endcase
        end

        // Hold reset, then release it at a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_flat_extremes();
        test_gray_planes();
        test_fringe();
        test_unused_codes();
        test_random_phases();

        // Drain, then watch for stray strobes.
        start = 1'b0;
        while (pending_levels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/slpg_pkg.sv
rtl/core/slpg_div_cell.sv
rtl/core/slpg_level_out.sv
rtl/core/structured_light_pattern_gen_core.sv
tb/tb_top.sv
